// ===== rtl/core/bba_pkg.sv =====
package bba_pkg;
   localparam int MIN_BLOCK_BYTES_DEF = 64;
   localparam int POOL_ORDER_DEF = 10;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_OOM = 2'd1;
   localparam logic [1:0] ST_BADFREE = 2'd2;
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;
endpackage

// ===== rtl/core/buddy_block_allocator_top.sv =====
// Buddy allocator, one request at a time; busy is high from acceptance until rsp_valid.
// Allocate: size the request, then read and test free-map nodes one at a time (up to
// 2^(POOL_ORDER+1)-1 nodes), split one level at a time, then record the order and respond.
// Free: look up the order and check it, then read and merge per level; a rejected free responds after the check.
// A new request is taken as the response shows; rsp_valid is one cycle, no stall.
// After reset a clearing pass over all 2^(POOL_ORDER+1) free-map entries runs with busy high.
module buddy_block_allocator_top #(
   parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF,
   parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [31:0] req_request_bytes,
   input  logic [15:0] req_free_address,
   output logic        rsp_valid,
   output logic [15:0] rsp_block_address,
   output logic [1:0]  rsp_status
);
   localparam int LW = POOL_ORDER;
   localparam int NW = POOL_ORDER + 1;
   localparam int NN = 1 << NW;
   localparam int OW = $clog2(POOL_ORDER + 2);
   localparam int MB = $clog2(MIN_BLOCK_BYTES);
   localparam logic [63:0] MINB = 64'(MIN_BLOCK_BYTES);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_SIZE, S_SCAN, S_SCANR, S_SPLIT, S_FIN,
      S_FLOOK, S_FCHK, S_FRD, S_FMRG, S_DONE
   } state_type;

   state_type state_ff;
   logic fmem [0:NN-1];
   logic fmdata_ff;
   logic [4:0] otab [0:(1<<LW)-1];
   logic [4:0] orddata_ff;
   logic [NW-1:0] clr_ff;
   logic [OW-1:0] order_ff, cur_ff;
   logic [LW-1:0] idx_ff;
   logic [63:0] blk_ff, size_ff;
   logic [15:0] faddr_ff;

   function automatic logic [NW-1:0] node(input logic [OW-1:0] o, input logic [LW-1:0] i);
      node = NW'((NW'(1) << (POOL_ORDER - int'(o))) - NW'(1)) + NW'(i);
   endfunction

   logic [LW-1:0] cnt_lim;
   assign cnt_lim = LW'((1 << (POOL_ORDER - int'(cur_ff))) - 1);
   logic [LW-1:0] leaf;
   assign leaf = LW'(faddr_ff >> MB);
   logic oob;
   assign oob = (32'(faddr_ff) >> MB) >= (32'd1 << LW);

   assign busy = state_ff != S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == S_DONE);
         unique case (state_ff)
            S_CLR: begin
               fmem[clr_ff] <= (clr_ff == '0);
               otab[clr_ff[LW-1:0]] <= '0;
               clr_ff <= clr_ff + NW'(1);
               if (clr_ff == '1) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               rsp_block_address <= '0;
               order_ff <= '0;
               blk_ff <= MINB;
               size_ff <= 64'(req_request_bytes);
               faddr_ff <= req_free_address;
               state_ff <= (req_cmd == bba_pkg::CMD_FREE) ? S_FLOOK : S_SIZE;
            end
            S_SIZE: begin
               if (blk_ff < size_ff && int'(order_ff) <= POOL_ORDER) begin
                  blk_ff <= blk_ff << 1;
                  order_ff <= order_ff + OW'(1);
               end else if (int'(order_ff) > POOL_ORDER) begin
                  rsp_status <= bba_pkg::ST_OOM;
                  state_ff <= S_DONE;
               end else begin
                  cur_ff <= order_ff;
                  idx_ff <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               fmdata_ff <= fmem[node(cur_ff, idx_ff)];
               state_ff <= S_SCANR;
            end
            S_SCANR: begin
               if (fmdata_ff) begin
                  fmem[node(cur_ff, idx_ff)] <= 1'b0;
                  state_ff <= S_SPLIT;
               end else if (idx_ff != cnt_lim) begin
                  idx_ff <= idx_ff + LW'(1);
                  state_ff <= S_SCAN;
               end else if (int'(cur_ff) == POOL_ORDER) begin
                  rsp_status <= bba_pkg::ST_OOM;
                  state_ff <= S_DONE;
               end else begin
                  cur_ff <= cur_ff + OW'(1);
                  idx_ff <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SPLIT: begin
               if (cur_ff > order_ff) begin
                  cur_ff <= cur_ff - OW'(1);
                  idx_ff <= idx_ff << 1;
                  fmem[node(cur_ff - OW'(1), (idx_ff << 1) + LW'(1))] <= 1'b1;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               otab[LW'(idx_ff << order_ff)] <= 5'(order_ff + OW'(1));
               rsp_block_address <= 16'((64'(idx_ff) << order_ff) << MB);
               rsp_status <= bba_pkg::ST_OK;
               state_ff <= S_DONE;
            end
            S_FLOOK: begin
               orddata_ff <= otab[leaf];
               state_ff <= S_FCHK;
            end
            S_FCHK: begin
               if ((faddr_ff & 16'(MIN_BLOCK_BYTES - 1)) != '0 || oob ||
                   orddata_ff == '0 || int'(orddata_ff) > POOL_ORDER + 1) begin
                  rsp_status <= bba_pkg::ST_BADFREE;
                  state_ff <= S_DONE;
               end else begin
                  order_ff <= OW'(orddata_ff - 5'd1);
                  idx_ff <= leaf >> (orddata_ff - 5'd1);
                  otab[leaf] <= '0;
                  state_ff <= S_FRD;
               end
            end
            S_FRD: begin
               fmdata_ff <= fmem[node(order_ff, idx_ff ^ LW'(1))] &&
                            int'(order_ff) < POOL_ORDER;
               state_ff <= S_FMRG;
            end
            S_FMRG: begin
               if (fmdata_ff) begin
                  fmem[node(order_ff, idx_ff ^ LW'(1))] <= 1'b0;
                  idx_ff <= idx_ff >> 1;
                  order_ff <= order_ff + OW'(1);
                  state_ff <= S_FRD;
               end else begin
                  fmem[node(order_ff, idx_ff)] <= 1'b1;
                  rsp_status <= bba_pkg::ST_OK;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== verif/tb_buddy_block_allocator_top.sv =====
`timescale 1ns / 100ps

module tb_buddy_block_allocator_top;
   localparam int MIN_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF;
   localparam int TOP_ORDER = bba_pkg::POOL_ORDER_DEF;
   localparam int LEAVES = 1 << TOP_ORDER;
   localparam int NODES = (2 << TOP_ORDER) - 1;
   localparam int POOL_BYTES = MIN_BYTES << TOP_ORDER;
   localparam int IDLE_LIMIT = 200000;
   localparam int N_RANDOM = 500;
   localparam logic [1:0] ST_NONE = 2'd3;

   typedef struct packed {
      logic [15:0] addr;
      logic [1:0]  status;
   } alloc_result_type;

   typedef struct {
      logic        cmd;
      logic [31:0] bytes;
      logic [15:0] addr;
      logic [1:0]  known_status;
      logic [15:0] known_addr;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_cmd;
   logic [31:0] req_request_bytes;
   logic [15:0] req_free_address;
   logic        rsp_valid;
   logic [15:0] rsp_block_address;
   logic [1:0]  rsp_status;

   bit               node_free [NODES];
   logic [4:0]       leaf_order [LEAVES];
   alloc_result_type pending_results [$];
   logic [15:0]      live_blocks [$];
   int               fail_count;
   int               idle_cycles;
   int               send_idle_pct;

   buddy_block_allocator_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_request_bytes(req_request_bytes),
      .req_free_address(req_free_address), .rsp_valid(rsp_valid),
      .rsp_block_address(rsp_block_address), .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int node_index(int order, int blk);
      return ((1 << (TOP_ORDER - order)) - 1) + blk;
   endfunction

   function automatic void pool_reset();
      foreach (node_free[i]) node_free[i] = 1'b0;
      foreach (leaf_order[i]) leaf_order[i] = '0;
      node_free[node_index(TOP_ORDER, 0)] = 1'b1;
   endfunction

   function automatic alloc_result_type pool_allocate(logic [31:0] bytes);
      alloc_result_type r;
      longint blk_bytes;
      int order;
      int lvl;
      int idx;
      bit found;
      r.addr = '0;
      r.status = bba_pkg::ST_OOM;
      order = 0;
      blk_bytes = MIN_BYTES;
      found = 1'b0;
      idx = 0;
      while (blk_bytes < longint'(bytes) && order <= TOP_ORDER) begin
         blk_bytes = blk_bytes << 1;
         order++;
      end
      if (order > TOP_ORDER) return r;
      for (lvl = order; lvl <= TOP_ORDER && !found; lvl++) begin
         for (int i = 0; i < (1 << (TOP_ORDER - lvl)); i++) begin
            if (node_free[node_index(lvl, i)]) begin
               idx = i;
               found = 1'b1;
               break;
            end
         end
         if (found) break;
      end
      if (!found) return r;
      node_free[node_index(lvl, idx)] = 1'b0;
      while (lvl > order) begin
         lvl--;
         idx = idx << 1;
         node_free[node_index(lvl, idx + 1)] = 1'b1;
      end
      leaf_order[(idx << order) & (LEAVES - 1)] = 5'(order + 1);
      r.addr = 16'(longint'(idx) * (longint'(MIN_BYTES) << order));
      r.status = bba_pkg::ST_OK;
      return r;
   endfunction

   function automatic alloc_result_type pool_release(logic [15:0] addr);
      alloc_result_type r;
      int leaf;
      int order;
      int idx;
      r.addr = '0;
      r.status = bba_pkg::ST_BADFREE;
      if (addr % MIN_BYTES != 0) return r;
      leaf = addr / MIN_BYTES;
      if (leaf >= LEAVES || leaf_order[leaf] == 0 || leaf_order[leaf] > TOP_ORDER + 1)
         return r;
      order = leaf_order[leaf] - 1;
      leaf_order[leaf] = '0;
      idx = leaf >> order;
      while (order < TOP_ORDER) begin
         if (!node_free[node_index(order, idx ^ 1)]) break;
         node_free[node_index(order, idx ^ 1)] = 1'b0;
         idx = idx >> 1;
         order++;
      end
      node_free[node_index(order, idx)] = 1'b1;
      r.status = bba_pkg::ST_OK;
      return r;
   endfunction

   task automatic send_request(logic cmd, logic [31:0] bytes, logic [15:0] addr,
                               logic [1:0] known_status, logic [15:0] known_addr);
      alloc_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_request_bytes <= bytes;
      req_free_address <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = (cmd == bba_pkg::CMD_ALLOC) ? pool_allocate(bytes) : pool_release(addr);
      if (known_status != ST_NONE &&
          (r.status != known_status || r.addr != known_addr)) begin
         $error("table row disagrees: status %0d/%0d addr %0h/%0h",
                known_status, r.status, known_addr, r.addr);
         fail_count++;
      end
      if (cmd == bba_pkg::CMD_ALLOC && r.status == bba_pkg::ST_OK)
         live_blocks.push_back(r.addr);
      if (cmd == bba_pkg::CMD_FREE && r.status == bba_pkg::ST_OK)
         foreach (live_blocks[i])
            if (live_blocks[i] == addr) begin
               live_blocks.delete(i);
               break;
            end
      pending_results.push_back(r);
   endtask

   function automatic logic [31:0] random_bytes();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return $urandom();
      if (sel == 1) return $urandom_range(MIN_BYTES);
      return $urandom_range(MIN_BYTES << $urandom_range(TOP_ORDER - 3));
   endfunction

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("unexpected response: status %0d addr %0h",
                      rsp_status, rsp_block_address);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_block_address !== want.addr) begin
                  $error("block_address: expected %0h actual %0h",
                         want.addr, rsp_block_address);
                  fail_count++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   stim_row_type directed [] = '{
      '{bba_pkg::CMD_FREE,  32'd0,              16'h0000, bba_pkg::ST_BADFREE, 16'h0000},
      '{bba_pkg::CMD_ALLOC, 32'hFFFFFFFF,       16'h0000, bba_pkg::ST_OOM,     16'h0000},
      '{bba_pkg::CMD_ALLOC, 32'(POOL_BYTES + 1), 16'h0000, bba_pkg::ST_OOM,    16'h0000},
      '{bba_pkg::CMD_ALLOC, 32'd0,              16'h0000, bba_pkg::ST_OK,      16'h0000},
      '{bba_pkg::CMD_ALLOC, 32'd1,              16'h0000, bba_pkg::ST_OK,      16'h0040},
      '{bba_pkg::CMD_ALLOC, 32'(MIN_BYTES + 1), 16'h0000, ST_NONE,             16'h0000},
      '{bba_pkg::CMD_FREE,  32'd0,              16'h0041, bba_pkg::ST_BADFREE, 16'h0000},
      '{bba_pkg::CMD_FREE,  32'd0,              16'hFFC0, bba_pkg::ST_BADFREE, 16'h0000},
      '{bba_pkg::CMD_FREE,  32'd0,              16'h0040, bba_pkg::ST_OK,      16'h0000},
      '{bba_pkg::CMD_FREE,  32'd0,              16'h0040, bba_pkg::ST_BADFREE, 16'h0000},
      '{bba_pkg::CMD_FREE,  32'd0,              16'h0000, bba_pkg::ST_OK,      16'h0000},
      '{bba_pkg::CMD_FREE,  32'd0,              16'h0080, bba_pkg::ST_OK,      16'h0000},
      '{bba_pkg::CMD_ALLOC, 32'(POOL_BYTES),    16'hFFFF, bba_pkg::ST_OK,      16'h0000},
      '{bba_pkg::CMD_ALLOC, 32'd0,              16'h0000, bba_pkg::ST_OOM,     16'h0000},
      '{bba_pkg::CMD_FREE,  32'hFFFFFFFF,       16'h0000, bba_pkg::ST_OK,      16'h0000},
      '{bba_pkg::CMD_ALLOC, 32'(POOL_BYTES / 2), 16'h0000, bba_pkg::ST_OK,     16'h0000},
      '{bba_pkg::CMD_ALLOC, 32'(POOL_BYTES / 2), 16'h0000, bba_pkg::ST_OK,     16'h8000},
      '{bba_pkg::CMD_ALLOC, 32'd1,              16'h0000, bba_pkg::ST_OOM,     16'h0000},
      '{bba_pkg::CMD_FREE,  32'd0,              16'h8000, bba_pkg::ST_OK,      16'h0000},
      '{bba_pkg::CMD_FREE,  32'd0,              16'h0000, bba_pkg::ST_OK,      16'h0000}
   };

   initial begin
      logic [15:0] addr;
      int k;
      fail_count = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = bba_pkg::CMD_ALLOC;
      req_request_bytes = '0;
      req_free_address = '0;
      pool_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i])
         send_request(directed[i].cmd, directed[i].bytes, directed[i].addr,
                      directed[i].known_status, directed[i].known_addr);
      for (int n = 0; n < N_RANDOM; n++) begin
         case ((n * 4) / N_RANDOM)
            0: send_idle_pct = 0;
            1: send_idle_pct = 70;
            2: send_idle_pct = 7;
            default: send_idle_pct = (n % 40 < 20) ? 0 : 70;
         endcase
         k = $urandom_range(99);
         if (k < 45) begin
            send_request(bba_pkg::CMD_ALLOC, random_bytes(), 16'($urandom()), ST_NONE, '0);
         end else if (k < 85 && live_blocks.size() > 0) begin
            addr = live_blocks[$urandom_range(live_blocks.size() - 1)];
            send_request(bba_pkg::CMD_FREE, $urandom(), addr, ST_NONE, '0);
         end else begin
            addr = (k < 92) ? 16'($urandom_range(LEAVES - 1) * MIN_BYTES)
                            : 16'($urandom());
            send_request(bba_pkg::CMD_FREE, $urandom(), addr, ST_NONE, '0);
         end
      end
      start <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
